/* design/afp_pkg.sv */
// Shared constants, event codes and result type for the ASCII field frame parser.
package afp_pkg;

  // Default cap on the stored argument count
  localparam int unsigned AFP_MAX_ARGS = 255;

  // Framing characters
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // Event codes carried on tuser
  localparam logic [2:0] EV_CONTENT = 3'd0;
  localparam logic [2:0] EV_SEP     = 3'd1;
  localparam logic [2:0] EV_ACCEPT  = 3'd2;
  localparam logic [2:0] EV_REJECT  = 3'd3;
  localparam logic [2:0] EV_START   = 3'd4;

  // One result beat
  typedef struct packed {
    logic [7:0]  echo_byte;
    logic [8:0]  field_number;
    logic [2:0]  event_res;
    logic [7:0]  stored_args;
    logic [31:0] declared_args;
    logic        command_flag;
  } afp_result_t;

endpackage

/* design/afp_parse.sv */
// Frame state machine: decodes one byte against the frame state and updates it.
module afp_parse import afp_pkg::*; #(
  parameter int unsigned MAX_ARGS = AFP_MAX_ARGS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,        // consume data_byte this cycle
  input  logic [7:0]  data_byte,
  output logic        has_result,  // the byte yields a result beat
  output afp_result_t result
);

  localparam int unsigned ArgCapInt = (MAX_ARGS < 255) ? MAX_ARGS : 255;
  localparam logic [7:0]  ArgCap    = ArgCapInt[7:0];

  // Phase codes
  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_ID    = 3'd1;
  localparam logic [2:0] PH_FLAG  = 3'd2;
  localparam logic [2:0] PH_COUNT = 3'd3;
  localparam logic [2:0] PH_ARGS  = 3'd4;

  logic [2:0]  phase, phase_next;
  logic        field_nonempty, field_nonempty_next;
  logic [7:0]  arg_counter, arg_counter_next;
  logic [31:0] count_value, count_value_next;
  logic        count_digits_done, count_digits_done_next;
  logic [1:0]  flag_match, flag_match_next;
  logic        frame_bad, frame_bad_next;

  logic [8:0]  field_num;
  logic [2:0]  ev;
  logic        is_sep;
  logic        is_digit;
  logic [35:0] count_acc;

  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  // value * 10 + digit as two shifts and two adds
  assign count_acc = {1'b0, count_value, 3'b000} + {3'b000, count_value, 1'b0}
                   + {28'd0, data_byte - CH_ZERO};

  // Decode the byte and work out the next frame state
  always_comb begin
    phase_next             = phase;
    field_nonempty_next    = field_nonempty;
    arg_counter_next       = arg_counter;
    count_value_next       = count_value;
    count_digits_done_next = count_digits_done;
    flag_match_next        = flag_match;
    frame_bad_next         = frame_bad;
    has_result             = 1'b1;
    field_num              = 9'd0;
    ev                     = EV_CONTENT;
    is_sep                 = 1'b0;

    case (phase)
      PH_ID, PH_FLAG, PH_COUNT, PH_ARGS: begin
        if (data_byte == CH_STAR) begin
          // End of frame: report and return to hunting
          ev = ((phase == PH_ARGS) && !frame_bad) ? EV_ACCEPT : EV_REJECT;
          case (phase)
            PH_ID:    field_num = 9'd0;
            PH_FLAG:  field_num = 9'd1;
            PH_COUNT: field_num = 9'd2;
            default:  field_num = 9'd2 + {1'b0, arg_counter};
          endcase
          phase_next = PH_HUNT;
        end else if (phase == PH_ARGS) begin
          // Open an argument at its first byte
          if (!field_nonempty && (arg_counter < ArgCap)) begin
            arg_counter_next = arg_counter + 8'd1;
          end
          field_nonempty_next = (data_byte != CH_COMMA);
          ev        = (data_byte == CH_COMMA) ? EV_SEP : EV_CONTENT;
          field_num = 9'd2 + {1'b0, arg_counter_next};
        end else begin
          case (phase)
            PH_ID:   field_num = 9'd0;
            PH_FLAG: field_num = 9'd1;
            default: field_num = 9'd2;
          endcase
          is_sep = (phase == PH_COUNT) ? (data_byte == CH_SEMI) : (data_byte == CH_COMMA);
          if (is_sep) begin
            // Close a header field; an empty one spoils the frame
            if (!field_nonempty) begin
              frame_bad_next = 1'b1;
            end
            field_nonempty_next = 1'b0;
            phase_next          = phase + 3'd1;
            ev                  = EV_SEP;
          end else begin
            field_nonempty_next = 1'b1;
            if (phase == PH_FLAG) begin
              flag_match_next = ((flag_match == 2'd0) && (data_byte == CH_ONE)) ? 2'd1 : 2'd2;
            end else if ((phase == PH_COUNT) && !count_digits_done) begin
              if (is_digit) begin
                count_value_next = (count_acc[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                : count_acc[31:0];
              end else begin
                count_digits_done_next = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        // Hunting: drop everything but the start mark
        phase_next = PH_HUNT;
        if (data_byte == CH_HASH) begin
          phase_next             = PH_ID;
          field_nonempty_next    = 1'b0;
          arg_counter_next       = 8'd0;
          count_value_next       = 32'd0;
          count_digits_done_next = 1'b0;
          flag_match_next        = 2'd0;
          frame_bad_next         = 1'b0;
          ev                     = EV_START;
        end else begin
          has_result = 1'b0;
        end
      end
    endcase

    result.echo_byte     = data_byte;
    result.field_number  = field_num;
    result.event_res     = ev;
    result.stored_args   = arg_counter_next;
    result.declared_args = count_value_next;
    result.command_flag  = (flag_match_next == 2'd1);
  end

  // Hold the frame state; advance on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      field_nonempty    <= 1'b0;
      arg_counter       <= 8'd0;
      count_value       <= 32'd0;
      count_digits_done <= 1'b0;
      flag_match        <= 2'd0;
      frame_bad         <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      field_nonempty    <= field_nonempty_next;
      arg_counter       <= arg_counter_next;
      count_value       <= count_value_next;
      count_digits_done <= count_digits_done_next;
      flag_match        <= flag_match_next;
      frame_bad         <= frame_bad_next;
    end
  end

endmodule

/* design/ascii_field_frame_parser_top.sv */
// A byte taken at the input is held in the input register, parsed, and its result stored in the result register.
// The parser takes one byte per cycle while the output is not stalled and updates its frame state per byte.
// Bytes dropped while hunting take a slot in the input register but give no result beat.
// Input ready follows output ready combinationally; a stalled output holds one byte per register.
// Reset (synchronous, active high) empties both registers and returns the parser to hunting.
// Top level of the ASCII field frame parser: input register, parser, result register.
module ascii_field_frame_parser_top import afp_pkg::*; #(
  parameter int unsigned MAX_ARGS = AFP_MAX_ARGS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] echo_byte, [16:8] field_number, [24:17] stored_args,
  // [56:25] declared_args, [57] command_flag, [63:58] zero
  output logic [63:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser    // [2:0] event_res
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        advance;
  logic        has_result;
  afp_result_t result;
  afp_result_t out_res;

  // Move the held byte on when the result register is free or being drained
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  afp_parse #(
    .MAX_ARGS (MAX_ARGS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (in_byte),
    .has_result (has_result),
    .result     (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= has_result;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_res <= result;
    end
  end

  // Pack the result beat
  assign m_axis_tdata = {6'd0, out_res.command_flag, out_res.declared_args,
                         out_res.stored_args, out_res.field_number, out_res.echo_byte};
  assign m_axis_tuser = out_res.event_res;

`ifndef SYNTHESIS
  localparam int unsigned CapInt = (MAX_ARGS < 255) ? MAX_ARGS : 255;

  // A frame start beat echoes the start mark and carries cleared totals
  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == EV_START)) |->
      ((m_axis_tdata[7:0] == CH_HASH) && (m_axis_tdata[57:8] == 50'd0)))
    else $error("frame start beat not clean");

  // Accept and reject beats are only ever caused by the end mark
  a_end_star: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && ((m_axis_tuser == EV_ACCEPT) || (m_axis_tuser == EV_REJECT))) |->
      (m_axis_tdata[7:0] == CH_STAR))
    else $error("frame end beat without end mark");

  // Argument count stays within its cap
  a_arg_cap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[24:17] <= CapInt[7:0]))
    else $error("stored argument count above cap");

  // An accepted frame has at least reached the argument field
  a_accept_field: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == EV_ACCEPT)) |-> (m_axis_tdata[16:8] >= 9'd2))
    else $error("frame accepted inside header");
`endif

endmodule

/* tb/sv/testbench.sv */
// Stream testbench for the ASCII field frame parser: directed table, random frames, scoreboard.
`timescale 1ns / 1ps

module testbench;
  import afp_pkg::*;

  localparam int unsigned ARG_CAP = (AFP_MAX_ARGS < 255) ? AFP_MAX_ARGS : 255;
  localparam int RANDOM_BYTES    = 550;
  localparam int CALM_TAIL       = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 4000;
  localparam int LONG_FRAME_ARGS = 258;

  typedef enum logic [2:0] {P_HUNT, P_ID, P_FLAG, P_COUNT, P_ARGS} parse_phase_t;

  localparam logic [1:0] FLAG_UNSEEN = 2'd0;
  localparam logic [1:0] FLAG_ONE    = 2'd1;
  localparam logic [1:0] FLAG_OTHER  = 2'd2;

  // One row of the directed table; fixed rows carry their expectation inline
  typedef struct packed {
    logic [7:0]  data;
    logic        fixed;
    logic        gives;
    afp_result_t res;
  } table_row_t;

  localparam afp_result_t NO_BEAT        = '0;
  localparam afp_result_t START_BEAT     = '{CH_HASH, 9'd0, EV_START, 8'd0, 32'd0, 1'b0};
  localparam afp_result_t REJECT_IN_ID   = '{CH_STAR, 9'd0, EV_REJECT, 8'd0, 32'd0, 1'b0};
  localparam afp_result_t REJECT_IN_FLAG = '{CH_STAR, 9'd1, EV_REJECT, 8'd0, 32'd0, 1'b0};

  localparam int DIRECTED_ROWS = 25;
  localparam table_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'h00,    1'b1, 1'b0, NO_BEAT},        // drop while hunting
    '{8'hFF,    1'b1, 1'b0, NO_BEAT},        // drop while hunting
    '{CH_STAR,  1'b1, 1'b0, NO_BEAT},        // end mark while hunting is dropped
    '{CH_HASH,  1'b1, 1'b1, START_BEAT},
    '{8'h41,    1'b0, 1'b0, NO_BEAT},        // 'A' in id
    '{CH_SEMI,  1'b0, 1'b0, NO_BEAT},        // ';' in id is content
    '{CH_COMMA, 1'b0, 1'b0, NO_BEAT},
    '{CH_ONE,   1'b0, 1'b0, NO_BEAT},        // flag exactly "1"
    '{CH_COMMA, 1'b0, 1'b0, NO_BEAT},
    '{8'h34,    1'b0, 1'b0, NO_BEAT},        // '4'
    '{8'h32,    1'b0, 1'b0, NO_BEAT},        // '2'
    '{8'h78,    1'b0, 1'b0, NO_BEAT},        // 'x' stops the digits
    '{8'h37,    1'b0, 1'b0, NO_BEAT},        // '7' after the stop is ignored
    '{CH_COMMA, 1'b0, 1'b0, NO_BEAT},        // ',' in count is content
    '{CH_SEMI,  1'b0, 1'b0, NO_BEAT},
    '{CH_COMMA, 1'b0, 1'b0, NO_BEAT},        // empty argument is counted
    '{8'h62,    1'b0, 1'b0, NO_BEAT},        // 'b'
    '{CH_HASH,  1'b0, 1'b0, NO_BEAT},        // '#' inside a frame is content
    '{CH_STAR,  1'b0, 1'b0, NO_BEAT},        // accepted
    '{CH_HASH,  1'b1, 1'b1, START_BEAT},
    '{CH_COMMA, 1'b0, 1'b0, NO_BEAT},        // empty id marks the frame bad
    '{CH_STAR,  1'b1, 1'b1, REJECT_IN_FLAG}, // end mark before ';'
    '{CH_HASH,  1'b1, 1'b1, START_BEAT},
    '{CH_STAR,  1'b1, 1'b1, REJECT_IN_ID},   // end mark straight after start
    '{8'h80,    1'b1, 1'b0, NO_BEAT}         // back to hunting
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] echo_byte, [16:8] field_number, [24:17] stored_args,
  // [56:25] declared_args, [57] command_flag, [63:58] zero
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;          // [2:0] event_res

  // Parser state mirrored by the testbench
  parse_phase_t phase = P_HUNT;
  bit           field_open = 1'b0;
  logic [7:0]   arg_count = '0;
  logic [31:0]  count_val = '0;
  bit           count_stopped = 1'b0;
  logic [1:0]   flag_state = FLAG_UNSEEN;
  bit           header_bad = 1'b0;

  afp_result_t  pending_beats[$];
  logic [7:0]   byte_plan[$];
  int           errors = 0;
  int           beats_seen = 0;
  bit           calm = 1'b0;

  ascii_field_frame_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Clear everything a new frame starts from
  function automatic void start_frame();
    field_open    = 1'b0;
    arg_count     = '0;
    count_val     = '0;
    count_stopped = 1'b0;
    flag_state    = FLAG_UNSEEN;
    header_bad    = 1'b0;
  endfunction

  function automatic logic [8:0] field_of_phase();
    case (phase)
      P_ID:    return 9'd0;
      P_FLAG:  return 9'd1;
      P_COUNT: return 9'd2;
      default: return 9'd2 + 9'(arg_count);
    endcase
  endfunction

  function automatic afp_result_t make_beat(logic [7:0] b, logic [8:0] fld, logic [2:0] ev);
    return '{b, fld, ev, arg_count, count_val, flag_state == FLAG_ONE};
  endfunction

  // Advance the mirrored parser by one byte; returns 1 when the byte gives a beat
  function automatic bit parse_byte(input logic [7:0] b, output afp_result_t beat);
    logic [8:0]  fld;
    logic [35:0] scaled;
    beat = '0;
    if (phase == P_HUNT) begin
      if (b != CH_HASH) return 1'b0;
      start_frame();
      phase = P_ID;
      beat  = make_beat(b, 9'd0, EV_START);
      return 1'b1;
    end
    // end mark closes the frame wherever it lands
    if (b == CH_STAR) begin
      beat  = make_beat(b, field_of_phase(),
                        (phase == P_ARGS && !header_bad) ? EV_ACCEPT : EV_REJECT);
      phase = P_HUNT;
      return 1'b1;
    end
    // arguments are counted at their first byte
    if (phase == P_ARGS) begin
      if (!field_open) begin
        if (arg_count < ARG_CAP) arg_count++;
        field_open = 1'b1;
      end
      if (b == CH_COMMA) field_open = 1'b0;
      beat = make_beat(b, field_of_phase(), (b == CH_COMMA) ? EV_SEP : EV_CONTENT);
      return 1'b1;
    end
    fld = field_of_phase();
    if ((phase == P_COUNT) ? (b == CH_SEMI) : (b == CH_COMMA)) begin
      if (!field_open) header_bad = 1'b1;
      field_open = 1'b0;
      phase = (phase == P_ID) ? P_FLAG : (phase == P_FLAG) ? P_COUNT : P_ARGS;
      beat  = make_beat(b, fld, EV_SEP);
      return 1'b1;
    end
    field_open = 1'b1;
    if (phase == P_FLAG) begin
      flag_state = (flag_state == FLAG_UNSEEN && b == CH_ONE) ? FLAG_ONE : FLAG_OTHER;
    end else if (phase == P_COUNT && !count_stopped) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        scaled    = 36'(count_val) * 36'd10 + 36'(b - CH_ZERO);
        count_val = (scaled > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
      end else begin
        count_stopped = 1'b1;
      end
    end
    beat = make_beat(b, fld, EV_CONTENT);
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte(logic [7:0] skip_a, logic [7:0] skip_b);
    logic [7:0] b;
    do b = 8'($urandom); while (b == skip_a || b == skip_b);
    return b;
  endfunction

  // Append one byte to the send plan
  function automatic void plan_byte(logic [7:0] b);
    byte_plan.insert(byte_plan.size(), b);
  endfunction

  // Queue one expected beat behind the others
  function automatic void expect_beat(afp_result_t r);
    pending_beats.insert(pending_beats.size(), r);
  endfunction

  function automatic void push_digits(int n);
    repeat (n) plan_byte(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // Plan one random frame, a broken frame or a run of noise
  function automatic void plan_frame();
    int    kind;
    int    nargs;
    string s;
    kind = $urandom_range(0, 9);
    if (kind == 8) begin
      // noise between frames
      repeat ($urandom_range(1, 6)) plan_byte(pick_byte(CH_HASH, CH_HASH));
    end else if (kind == 9) begin
      // broken frame: separators and marks in random order
      plan_byte(CH_HASH);
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 5))
          0: plan_byte(CH_COMMA);
          1: plan_byte(CH_SEMI);
          2: plan_byte(CH_HASH);
          3: plan_byte(CH_ONE);
          4: push_digits(1);
          default: plan_byte(pick_byte(CH_STAR, CH_STAR));
        endcase
      end
      plan_byte(CH_STAR);
    end else begin
      // well-formed shape with random content
      plan_byte(CH_HASH);
      repeat (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4))
        plan_byte(pick_byte(CH_STAR, CH_COMMA));
      plan_byte(CH_COMMA);
      case ($urandom_range(0, 5))
        0, 1, 2: plan_byte(CH_ONE);
        3: ;
        4: begin
          plan_byte(CH_ONE);
          plan_byte(pick_byte(CH_STAR, CH_COMMA));
        end
        default: repeat ($urandom_range(1, 3)) plan_byte(pick_byte(CH_STAR, CH_COMMA));
      endcase
      plan_byte(CH_COMMA);
      case ($urandom_range(0, 5))
        0, 1: push_digits($urandom_range(1, 3));
        2: begin
          if ($urandom_range(0, 1) == 1) begin
            s = ($urandom_range(0, 1) == 1) ? "4294967295" : "4294967296";
            foreach (s[i]) plan_byte(s[i]);
          end else begin
            push_digits($urandom_range(10, 12));
          end
        end
        3: begin
          plan_byte(($urandom_range(0, 1) == 1) ? 8'h2D : 8'h20);  // '-' or ' '
          push_digits($urandom_range(1, 3));
        end
        4: begin
          push_digits($urandom_range(1, 3));
          plan_byte(pick_byte(CH_STAR, CH_SEMI));
          push_digits($urandom_range(1, 3));
        end
        default: ;
      endcase
      plan_byte(CH_SEMI);
      nargs = $urandom_range(0, 5);
      for (int i = 0; i < nargs; i++) begin
        repeat ($urandom_range(0, 3)) plan_byte(pick_byte(CH_STAR, CH_COMMA));
        if (i < nargs - 1 || $urandom_range(0, 3) == 0) plan_byte(CH_COMMA);
      end
      plan_byte(CH_STAR);
    end
  endfunction

  // Offer one byte, hold it until taken, then record what it should give
  task automatic send_byte(input logic [7:0] b, input logic fixed, input logic gives,
                           input afp_result_t fixed_beat, input int gap_odds);
    afp_result_t beat;
    bit          produced;
    if (gap_odds != 0 && !calm && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    produced = parse_byte(b, beat);
    if (fixed) begin
      if (gives) expect_beat(fixed_beat);
    end else if (produced) begin
      expect_beat(beat);
    end
  endtask

  function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    errors++;
  endfunction

  // Compare one output beat with the oldest expectation
  function automatic void check_beat(input logic [63:0] data, input logic [2:0] ev);
    afp_result_t got;
    afp_result_t want;
    got = '{data[7:0], data[16:8], ev, data[24:17], data[56:25], data[57]};
    beats_seen++;
    if (pending_beats.size() == 0) begin
      $display("%0t: beat mismatch: expected none, actual byte %0h field %0d event %0d",
               $time, got.echo_byte, got.field_number, got.event_res);
      errors++;
    end else begin
      want = pending_beats.pop_front();
      if (got.echo_byte !== want.echo_byte)
        report_field("echo_byte", 32'(want.echo_byte), 32'(got.echo_byte));
      if (got.field_number !== want.field_number)
        report_field("field_number", 32'(want.field_number), 32'(got.field_number));
      if (got.event_res !== want.event_res)
        report_field("event_res", 32'(want.event_res), 32'(got.event_res));
      if (got.stored_args !== want.stored_args)
        report_field("stored_args", 32'(want.stored_args), 32'(got.stored_args));
      if (got.declared_args !== want.declared_args)
        report_field("declared_args", want.declared_args, got.declared_args);
      if (got.command_flag !== want.command_flag)
        report_field("command_flag", 32'(want.command_flag), 32'(got.command_flag));
    end
  endfunction

  // Sender: directed table, then random frames
  initial begin
    int gap_odds;
    bit long_planned;
    gap_odds     = 4;
    long_planned = 1'b0;
    while (byte_plan.size() < RANDOM_BYTES) begin
      if (!long_planned && byte_plan.size() > 150) begin
        // one frame with more arguments than the cap holds
        long_planned = 1'b1;
        plan_byte(CH_HASH);
        plan_byte(8'h61);  // 'a'
        plan_byte(CH_COMMA);
        plan_byte(CH_ONE);
        plan_byte(CH_COMMA);
        plan_byte(8'h33);  // '3'
        plan_byte(CH_SEMI);
        repeat (LONG_FRAME_ARGS) plan_byte(CH_COMMA);
        plan_byte(8'h7A);  // 'z'
        plan_byte(CH_STAR);
      end else begin
        plan_frame();
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_byte(DIRECTED[i].data, DIRECTED[i].fixed, DIRECTED[i].gives, DIRECTED[i].res, 4);

    foreach (byte_plan[i]) begin
      // vary the sender's idling from one stretch to the next
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_odds = 0;
          1: gap_odds = 4;
          default: gap_odds = 8;
        endcase
      end
      calm = (i >= byte_plan.size() - CALM_TAIL);
      send_byte(byte_plan[i], 1'b0, 1'b0, NO_BEAT, gap_odds);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow for stray beats
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("ascii_field_frame_parser_top test passed");
    else $display("ascii_field_frame_parser_top test failed");
    $finish;
  end

  // Receiver: check beats, stall in bursts, hold off once for a long stretch
  initial begin
    int stall_left;
    bit held_long;
    stall_left = 0;
    held_long  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) check_beat(m_axis_tdata, m_axis_tuser);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!held_long && beats_seen >= 120) begin
        held_long  = 1'b1;
        stall_left = HOLD_OFF_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when neither side moves for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("ascii_field_frame_parser_top test failed");
    $finish;
  end

endmodule
